// ===== hdl/dcp_pkg.sv =====
`default_nettype none

package dcp_pkg;

   localparam int CoordWidth = 32;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int MagWidth   = CoordWidth + 1;
   localparam int MobWidth   = 17;
   localparam int MsumWidth  = MobWidth + 1;
   localparam int SqWidth    = 2 * MagWidth;
   localparam int RootWidth  = MagWidth + 1;
   localparam int SumWidth   = 2 * RootWidth;
   localparam int DistWidth  = RootWidth + 2;
   localparam int DmagWidth  = RootWidth + 1;
   localparam int DmagSplit  = 18;
   localparam int LoWidth    = MagWidth + DmagSplit;
   localparam int HiWidth    = MagWidth + DmagWidth - DmagSplit;
   localparam int ProdWidth  = MagWidth + DmagWidth;
   localparam int ProdSplit  = ProdWidth / 2;
   localparam int PartWidth  = ProdWidth - ProdSplit + MobWidth;
   localparam int NumWidth   = ProdWidth + MobWidth;
   localparam int DenWidth   = MsumWidth + RootWidth;
   localparam int QuotWidth  = CoordWidth;
   localparam int Axes       = 3;
   localparam int Lanes      = 2 * Axes;

   typedef enum logic [1:0] {
      KIND_RIGID,
      KIND_SUPPLE,
      KIND_IDENTITY,
      KIND_BREAKABLE
   } kind_type;

   typedef struct packed {
      kind_type                               kind;
      logic [Axes-1:0]                        dv_neg;
      logic [Axes-1:0][MagWidth-1:0]          dv_mag;
      logic [MobWidth-1:0]                    mob_first;
      logic [MobWidth-1:0]                    mob_second;
      logic signed [CoordWidth-1:0]           len_a;
      logic signed [CoordWidth-1:0]           len_b;
   } front_type;

   typedef struct packed {
      logic [Lanes-1:0] neg;
      logic             broken;
      logic             fault;
   } div_side_type;

endpackage

`default_nettype wire

// ===== hdl/dcp_if.sv =====
`default_nettype none

interface dcp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            kind;
   logic signed [dcp_pkg::CoordWidth-1:0] first_x;
   logic signed [dcp_pkg::CoordWidth-1:0] first_y;
   logic signed [dcp_pkg::CoordWidth-1:0] first_z;
   logic signed [dcp_pkg::CoordWidth-1:0] second_x;
   logic signed [dcp_pkg::CoordWidth-1:0] second_y;
   logic signed [dcp_pkg::CoordWidth-1:0] second_z;
   logic [dcp_pkg::MobWidth-1:0]          first_mobility;
   logic [dcp_pkg::MobWidth-1:0]          second_mobility;
   logic signed [dcp_pkg::CoordWidth-1:0] length_a;
   logic signed [dcp_pkg::CoordWidth-1:0] length_b;

   modport source (
      output valid, kind, first_x, first_y, first_z, second_x, second_y, second_z,
             first_mobility, second_mobility, length_a, length_b,
      input  ready
   );
   modport sink (
      input  valid, kind, first_x, first_y, first_z, second_x, second_y, second_z,
             first_mobility, second_mobility, length_a, length_b,
      output ready
   );
endinterface

interface dcp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dcp_pkg::CoordWidth-1:0] move_first_x;
   logic signed [dcp_pkg::CoordWidth-1:0] move_first_y;
   logic signed [dcp_pkg::CoordWidth-1:0] move_first_z;
   logic signed [dcp_pkg::CoordWidth-1:0] move_second_x;
   logic signed [dcp_pkg::CoordWidth-1:0] move_second_y;
   logic signed [dcp_pkg::CoordWidth-1:0] move_second_z;
   logic                                  broken;
   logic                                  fault;

   modport source (
      output valid, move_first_x, move_first_y, move_first_z,
             move_second_x, move_second_y, move_second_z, broken, fault,
      input  ready
   );
   modport sink (
      input  valid, move_first_x, move_first_y, move_first_z,
             move_second_x, move_second_y, move_second_z, broken, fault,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/dcp_sqrt.sv =====
`default_nettype none

module dcp_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  logic [dcp_pkg::SumWidth-1:0] radicand_in,
   input  dcp_pkg::front_type           carry_in,
   output logic                         valid_out,
   output logic [dcp_pkg::RootWidth-1:0] root_out,
   output dcp_pkg::front_type           carry_out
);
   import dcp_pkg::*;

   logic [RootWidth-1:0] valid_ff;
   logic [SumWidth-1:0]  rem_ff   [RootWidth];
   logic [RootWidth-1:0] res_ff   [RootWidth];
   front_type            carry_ff [RootWidth];

   logic [RootWidth-1:0] valid_src;
   logic [SumWidth-1:0]  rem_src  [RootWidth];
   logic [RootWidth-1:0] res_src  [RootWidth];
   front_type            carry_src[RootWidth];
   logic [SumWidth-1:0]  trial    [RootWidth];
   logic [SumWidth-1:0]  rem_in   [RootWidth];
   logic [RootWidth-1:0] res_in   [RootWidth];

   always_comb begin
      valid_src[0] = valid_in;
      rem_src[0]   = radicand_in;
      res_src[0]   = '0;
      carry_src[0] = carry_in;
      for (int s = 1; s < RootWidth; s++) begin
         valid_src[s] = valid_ff[s-1];
         rem_src[s]   = rem_ff[s-1];
         res_src[s]   = res_ff[s-1];
         carry_src[s] = carry_ff[s-1];
      end
      for (int s = 0; s < RootWidth; s++) begin
         trial[s] = ({{RootWidth{1'b0}}, res_src[s]} << (RootWidth - s))
                  | (SumWidth'(1) << (2 * (RootWidth - 1 - s)));
         if (rem_src[s] >= trial[s]) begin
            rem_in[s] = rem_src[s] - trial[s];
            res_in[s] = res_src[s] | (RootWidth'(1) << (RootWidth - 1 - s));
         end else begin
            rem_in[s] = rem_src[s];
            res_in[s] = res_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_src;
      end
      if (en) begin
         for (int s = 0; s < RootWidth; s++) begin
            rem_ff[s]   <= rem_in[s];
            res_ff[s]   <= res_in[s];
            carry_ff[s] <= carry_src[s];
         end
      end
   end

   assign valid_out = valid_ff[RootWidth-1];
   assign root_out  = res_ff[RootWidth-1];
   assign carry_out = carry_ff[RootWidth-1];

endmodule

`default_nettype wire

// ===== hdl/dcp_div.sv =====
`default_nettype none

module dcp_div (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          valid_in,
   input  logic [dcp_pkg::Lanes-1:0][dcp_pkg::NumWidth-1:0] num_in,
   input  logic [dcp_pkg::DenWidth-1:0]                  den_in,
   input  dcp_pkg::div_side_type                         side_in,
   output logic                                          valid_out,
   output logic [dcp_pkg::Lanes-1:0][dcp_pkg::CoordWidth-1:0] move_out,
   output logic                                          broken_out,
   output logic                                          fault_out
);
   import dcp_pkg::*;

   localparam int Steps = QuotWidth + 1;
   localparam logic [QuotWidth-1:0] NegLimit = QuotWidth'(1) << (QuotWidth - 1);
   localparam logic [QuotWidth-1:0] PosLimit = ~NegLimit;

   logic [Steps-1:0]                        valid_ff;
   logic [Lanes-1:0][NumWidth-1:0]          rem_ff  [Steps];
   logic [Lanes-1:0][QuotWidth-1:0]         quot_ff [Steps];
   logic [Lanes-1:0]                        ovf_ff  [Steps];
   logic [DenWidth-1:0]                     den_ff  [Steps];
   div_side_type                            side_ff [Steps];

   logic [Lanes-1:0][NumWidth-1:0]          rem_in  [Steps];
   logic [Lanes-1:0][QuotWidth-1:0]         quot_in [Steps];
   logic [Lanes-1:0]                        ovf_first;
   logic [NumWidth-1:0]                     trial;

   logic                                    out_valid_ff;
   logic [Lanes-1:0][CoordWidth-1:0]        move_ff;
   logic [Lanes-1:0][CoordWidth-1:0]        move_in;
   logic                                    broken_ff;
   logic                                    fault_ff;

   always_comb begin
      trial = '0;
      for (int l = 0; l < Lanes; l++) begin
         ovf_first[l]  = num_in[l] >= (NumWidth'(den_in) << QuotWidth);
         rem_in[0][l]  = num_in[l];
         quot_in[0][l] = '0;
      end
      for (int k = 1; k < Steps; k++) begin
         trial = NumWidth'(den_ff[k-1]) << (QuotWidth - k);
         for (int l = 0; l < Lanes; l++) begin
            if (rem_ff[k-1][l] >= trial) begin
               rem_in[k][l]  = rem_ff[k-1][l] - trial;
               quot_in[k][l] = quot_ff[k-1][l] | (QuotWidth'(1) << (QuotWidth - k));
            end else begin
               rem_in[k][l]  = rem_ff[k-1][l];
               quot_in[k][l] = quot_ff[k-1][l];
            end
         end
      end
      for (int l = 0; l < Lanes; l++) begin
         priority if (side_ff[Steps-1].broken || side_ff[Steps-1].fault) begin
            move_in[l] = '0;
         end else if (side_ff[Steps-1].neg[l]) begin
            if (ovf_ff[Steps-1][l] || quot_ff[Steps-1][l] > NegLimit) begin
               move_in[l] = NegLimit;
            end else begin
               move_in[l] = -quot_ff[Steps-1][l];
            end
         end else if (ovf_ff[Steps-1][l] || quot_ff[Steps-1][l][QuotWidth-1]) begin
            move_in[l] = PosLimit;
         end else begin
            move_in[l] = quot_ff[Steps-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[Steps-2:0], valid_in};
         out_valid_ff <= valid_ff[Steps-1];
      end
      if (en) begin
         ovf_ff[0]  <= ovf_first;
         den_ff[0]  <= den_in;
         side_ff[0] <= side_in;
         for (int k = 0; k < Steps; k++) begin
            rem_ff[k]  <= rem_in[k];
            quot_ff[k] <= quot_in[k];
         end
         for (int k = 1; k < Steps; k++) begin
            ovf_ff[k]  <= ovf_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         move_ff   <= move_in;
         broken_ff <= side_ff[Steps-1].broken;
         fault_ff  <= side_ff[Steps-1].fault;
      end
   end

   assign valid_out  = out_valid_ff;
   assign move_out   = move_ff;
   assign broken_out = broken_ff;
   assign fault_out  = fault_ff;

endmodule

`default_nettype wire

// ===== hdl/distance_constraint_projection_top.sv =====
// Throughput: one word per cycle unless the output stalls; a 34-stage square root
// and a 33-stage divider, one quotient bit per stage after its first, set the depth.
// A stalled output word holds the whole pipeline.
// Reset: synchronous, active high, clears all valid bits; no clearing pass.
`default_nettype none

module distance_constraint_projection_top (
   input  logic      clock,
   input  logic      reset,
   dcp_req_if.sink   req_chan,
   dcp_rsp_if.source rsp_chan
);
   import dcp_pkg::*;

   typedef struct packed {
      front_type                  carry;
      logic [Axes-1:0][SqWidth-1:0] sq;
   } square_type;

   typedef struct packed {
      logic [DmagWidth-1:0]          dmag;
      logic [RootWidth-1:0]          nn;
      logic [MsumWidth-1:0]          msum;
      logic [MobWidth-1:0]           mob_first;
      logic [MobWidth-1:0]           mob_second;
      logic [Axes-1:0][MagWidth-1:0] dv_mag;
      div_side_type                  side;
   } dist_type;

   typedef struct packed {
      logic [Axes-1:0][LoWidth-1:0] lo;
      logic [Axes-1:0][HiWidth-1:0] hi;
      logic [DenWidth-1:0]          den;
      logic [MobWidth-1:0]          mob_first;
      logic [MobWidth-1:0]          mob_second;
      div_side_type                 side;
   } part_type;

   typedef struct packed {
      logic [Axes-1:0][ProdWidth-1:0] prod;
      logic [DenWidth-1:0]            den;
      logic [MobWidth-1:0]            mob_first;
      logic [MobWidth-1:0]            mob_second;
      div_side_type                   side;
   } prod_type;

   typedef struct packed {
      logic [Lanes-1:0][PartWidth-1:0] plo;
      logic [Lanes-1:0][PartWidth-1:0] phi;
      logic [DenWidth-1:0]             den;
      div_side_type                    side;
   } num_part_type;

   typedef struct packed {
      logic [Lanes-1:0][NumWidth-1:0] num;
      logic [DenWidth-1:0]            den;
      div_side_type                   side;
   } num_type;

   logic advance;
   logic div_valid;
   logic [Lanes-1:0][CoordWidth-1:0] moves;
   logic div_broken;
   logic div_fault;

   logic signed [CoordWidth-1:0] first_pos  [Axes];
   logic signed [CoordWidth-1:0] second_pos [Axes];
   logic signed [DiffWidth-1:0]  diff       [Axes];

   front_type    s1_in, s1_ff;
   square_type   s2_in, s2_ff;
   logic [SumWidth-1:0] s3_in, s3_ff;
   front_type    s3_carry_ff;
   logic [2:0]   front_valid_ff;

   logic                 root_valid;
   logic [RootWidth-1:0] root;
   front_type            root_carry;

   dist_type     s4_in, s4_ff;
   part_type     s5_in, s5_ff;
   prod_type     s6_in, s6_ff;
   num_part_type s7_in, s7_ff;
   num_type      s8_in, s8_ff;
   logic [4:0]   back_valid_ff;

   logic signed [DistWidth-1:0] root_s, len_a_s, len_b_s, delta, dist_abs;
   logic                        broken;
   logic [MobWidth-1:0]         lane_mob;

   assign advance        = !div_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      first_pos[0]  = req_chan.first_x;
      first_pos[1]  = req_chan.first_y;
      first_pos[2]  = req_chan.first_z;
      second_pos[0] = req_chan.second_x;
      second_pos[1] = req_chan.second_y;
      second_pos[2] = req_chan.second_z;
      s1_in.kind       = kind_type'(req_chan.kind);
      s1_in.mob_first  = req_chan.first_mobility;
      s1_in.mob_second = req_chan.second_mobility;
      s1_in.len_a      = req_chan.length_a;
      s1_in.len_b      = req_chan.length_b;
      for (int i = 0; i < Axes; i++) begin
         diff[i] = DiffWidth'(second_pos[i]) - DiffWidth'(first_pos[i]);
         s1_in.dv_neg[i] = diff[i][DiffWidth-1];
         s1_in.dv_mag[i] = diff[i][DiffWidth-1] ? MagWidth'(-diff[i]) : MagWidth'(diff[i]);
      end
   end

   always_comb begin
      s2_in.carry = s1_ff;
      for (int i = 0; i < Axes; i++) begin
         s2_in.sq[i] = SqWidth'(s1_ff.dv_mag[i]) * SqWidth'(s1_ff.dv_mag[i]);
      end
      s3_in = SumWidth'(s2_ff.sq[0]) + SumWidth'(s2_ff.sq[1]) + SumWidth'(s2_ff.sq[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (advance) begin
         front_valid_ff <= {front_valid_ff[1:0], req_chan.valid};
      end
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         s3_carry_ff <= s2_ff.carry;
      end
   end

   dcp_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .valid_in    (front_valid_ff[2]),
      .radicand_in (s3_ff),
      .carry_in    (s3_carry_ff),
      .valid_out   (root_valid),
      .root_out    (root),
      .carry_out   (root_carry)
   );

   always_comb begin
      root_s  = DistWidth'(signed'({1'b0, root}));
      len_a_s = DistWidth'(root_carry.len_a);
      len_b_s = DistWidth'(root_carry.len_b);
      unique case (root_carry.kind)
         KIND_RIGID: begin
            delta    = root_s - len_a_s;
            s4_in.nn = root;
         end
         KIND_SUPPLE: begin
            if (root_s < len_a_s) begin
               delta = root_s - len_a_s;
            end else if (root_s > len_b_s) begin
               delta = root_s - len_b_s;
            end else begin
               delta = '0;
            end
            s4_in.nn = root;
         end
         KIND_IDENTITY, KIND_BREAKABLE: begin
            delta    = DistWidth'(1);
            s4_in.nn = RootWidth'(1);
         end
      endcase
      broken     = (root_carry.kind == KIND_BREAKABLE)
                 && (root_s > len_a_s || len_a_s[DistWidth-1]);
      dist_abs   = delta[DistWidth-1] ? -delta : delta;
      s4_in.dmag = dist_abs[DmagWidth-1:0];
      s4_in.msum = MsumWidth'(root_carry.mob_first) + MsumWidth'(root_carry.mob_second);
      s4_in.mob_first   = root_carry.mob_first;
      s4_in.mob_second  = root_carry.mob_second;
      s4_in.dv_mag      = root_carry.dv_mag;
      s4_in.side.broken = broken;
      s4_in.side.fault  = !broken && (s4_in.nn == '0 || s4_in.msum == '0);
      for (int i = 0; i < Axes; i++) begin
         s4_in.side.neg[i]        = root_carry.dv_neg[i] ^ delta[DistWidth-1];
         s4_in.side.neg[Axes + i] = !(root_carry.dv_neg[i] ^ delta[DistWidth-1]);
      end
   end

   always_comb begin
      for (int i = 0; i < Axes; i++) begin
         s5_in.lo[i] = LoWidth'(s4_ff.dv_mag[i]) * LoWidth'(s4_ff.dmag[DmagSplit-1:0]);
         s5_in.hi[i] = HiWidth'(s4_ff.dv_mag[i]) * HiWidth'(s4_ff.dmag[DmagWidth-1:DmagSplit]);
      end
      s5_in.den        = DenWidth'(s4_ff.msum) * DenWidth'(s4_ff.nn);
      s5_in.mob_first  = s4_ff.mob_first;
      s5_in.mob_second = s4_ff.mob_second;
      s5_in.side       = s4_ff.side;

      for (int i = 0; i < Axes; i++) begin
         s6_in.prod[i] = ProdWidth'(s5_ff.lo[i]) + (ProdWidth'(s5_ff.hi[i]) << DmagSplit);
      end
      s6_in.den        = s5_ff.den;
      s6_in.mob_first  = s5_ff.mob_first;
      s6_in.mob_second = s5_ff.mob_second;
      s6_in.side       = s5_ff.side;

      lane_mob = '0;
      for (int l = 0; l < Lanes; l++) begin
         lane_mob = (l < Axes) ? s6_ff.mob_first : s6_ff.mob_second;
         s7_in.plo[l] = PartWidth'(s6_ff.prod[l % Axes][ProdSplit-1:0]) * PartWidth'(lane_mob);
         s7_in.phi[l] = PartWidth'(s6_ff.prod[l % Axes][ProdWidth-1:ProdSplit])
                      * PartWidth'(lane_mob);
      end
      s7_in.den  = s6_ff.den;
      s7_in.side = s6_ff.side;

      for (int l = 0; l < Lanes; l++) begin
         s8_in.num[l] = NumWidth'(s7_ff.plo[l]) + (NumWidth'(s7_ff.phi[l]) << ProdSplit);
      end
      s8_in.den  = s7_ff.den;
      s8_in.side = s7_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_valid_ff <= '0;
      end else if (advance) begin
         back_valid_ff <= {back_valid_ff[3:0], root_valid};
      end
      if (advance) begin
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

   dcp_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .valid_in   (back_valid_ff[4]),
      .num_in     (s8_ff.num),
      .den_in     (s8_ff.den),
      .side_in    (s8_ff.side),
      .valid_out  (div_valid),
      .move_out   (moves),
      .broken_out (div_broken),
      .fault_out  (div_fault)
   );

   assign rsp_chan.valid         = div_valid;
   assign rsp_chan.move_first_x  = moves[0];
   assign rsp_chan.move_first_y  = moves[1];
   assign rsp_chan.move_first_z  = moves[2];
   assign rsp_chan.move_second_x = moves[3];
   assign rsp_chan.move_second_y = moves[4];
   assign rsp_chan.move_second_z = moves[5];
   assign rsp_chan.broken        = div_broken;
   assign rsp_chan.fault         = div_fault;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.broken && rsp_chan.fault))
      else $error("broken and fault set on one word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.broken || rsp_chan.fault) |->
         rsp_chan.move_first_x == '0 && rsp_chan.move_first_y == '0
         && rsp_chan.move_first_z == '0 && rsp_chan.move_second_x == '0
         && rsp_chan.move_second_y == '0 && rsp_chan.move_second_z == '0)
      else $error("nonzero move on a broken or faulted word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.move_first_x[CoordWidth-1] && rsp_chan.move_first_x != '0
         |-> rsp_chan.move_second_x[CoordWidth-1] || rsp_chan.move_second_x == '0)
      else $error("x moves of both particles point the same way");
`endif

endmodule

`default_nettype wire
